// File: design/lrs_pkg.sv
package lrs_pkg;

  // Opcodes of an input word
  localparam logic [2:0] OP_STEP         = 3'd0;
  localparam logic [2:0] OP_BEGIN        = 3'd1;
  localparam logic [2:0] OP_BEGIN_CORNER = 3'd2;
  localparam logic [2:0] OP_RESET        = 3'd3;
  localparam logic [2:0] OP_COMMIT       = 3'd4;
  localparam logic [2:0] OP_STOP         = 3'd5;

  // Phase codes
  localparam logic [2:0] PH_IDLE          = 3'd0;
  localparam logic [2:0] PH_BRAKE_SEARCH  = 3'd1;
  localparam logic [2:0] PH_SEARCH        = 3'd2;
  localparam logic [2:0] PH_BRAKE_CAPTURE = 3'd3;
  localparam logic [2:0] PH_CONFIRM       = 3'd4;
  localparam logic [2:0] PH_CAPTURED      = 3'd5;
  localparam logic [2:0] PH_FAULT         = 3'd6;

  // Stop requests
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_COAST = 2'd1;
  localparam logic [1:0] REQ_BRAKE = 2'd2;

  // Outcome codes
  localparam logic [1:0] OUT_BUSY     = 2'd0;
  localparam logic [1:0] OUT_CAPTURED = 2'd1;
  localparam logic [1:0] OUT_FAILED   = 2'd2;

  // Stored reason for a drive fault
  localparam logic [2:0] REASON_NONE  = 3'd0;
  localparam logic [2:0] REASON_FAULT = 3'd1;

  // Configuration register indexes and reset values
  localparam logic [1:0] CFG_SEARCH_SPEED  = 2'd0;
  localparam logic [1:0] CFG_CONFIRM_MS    = 2'd1;
  localparam logic [1:0] CFG_STATIONARY_MS = 2'd2;

  localparam logic [14:0] SPEED_RESET      = 15'd300;
  localparam logic [15:0] CONFIRM_RESET    = 16'd20;
  localparam logic [15:0] STATIONARY_RESET = 16'd80;

  typedef struct packed {
    logic [14:0] search_speed;
    logic [15:0] confirm_ms;
    logic [15:0] stationary_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic        side_right;
    logic        candidate;
    logic [31:0] phase_start_time;
    logic [31:0] centred_since;
    logic [2:0]  reason_store;
  } state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        prefer_right;
    logic        sensor_one;
    logic        sensor_two;
    logic        sensor_three;
    logic        sensor_four;
    logic [31:0] now_ms;
    logic        drive_fault;
    logic        still_braking;
    logic [2:0]  stop_cause;
  } item_t;

  typedef struct packed {
    logic [1:0]         outcome;
    logic [1:0]         stop_request;
    logic               wheels_valid;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic               search_direction;
    logic [2:0]         halt_reason;
  } result_t;

endpackage

// File: design/lrs_step.sv
module lrs_step (
  input  lrs_pkg::cfg_t    cfg,
  input  lrs_pkg::state_t  state,
  input  lrs_pkg::item_t   item,
  output lrs_pkg::state_t  state_next,
  output lrs_pkg::result_t result
);
  import lrs_pkg::*;

  logic        visible;
  logic [31:0] since_base;
  logic [31:0] centred_elapsed;
  logic [31:0] phase_elapsed;
  logic        centred_hit;
  logic        done;
  logic [2:0]  cur_phase;
  logic [15:0] mag;
  logic [15:0] neg;

  // Line is centred when an odd sensor sees black and the even ones do not
  assign visible = (item.sensor_one | item.sensor_three) & ~item.sensor_two & ~item.sensor_four;

  // A fresh candidate starts timing at the current timestamp
  assign since_base      = state.candidate ? state.centred_since : item.now_ms;
  assign centred_elapsed = item.now_ms - since_base;
  assign centred_hit     = visible && (centred_elapsed >= {16'd0, cfg.confirm_ms});
  assign phase_elapsed   = item.now_ms - state.phase_start_time;

  assign cur_phase = item.drive_fault ? PH_FAULT : state.phase;

  assign mag = {1'b0, cfg.search_speed};
  assign neg = 16'd0 - mag;

  always_comb begin
    state_next              = state;
    result                  = '0;
    result.search_direction = state.side_right;
    done                    = 1'b0;

    case (item.opcode)
      OP_STEP: begin
        // Latch a drive fault before the phase work
        if (item.drive_fault) begin
          result.stop_request    = REQ_COAST;
          state_next.reason_store = REASON_FAULT;
          state_next.phase        = PH_FAULT;
        end
        case (cur_phase)
          PH_FAULT: begin
            result.outcome = OUT_FAILED;
            done           = 1'b1;
          end
          PH_CAPTURED: begin
            result.outcome = OUT_CAPTURED;
            done           = 1'b1;
          end
          PH_BRAKE_SEARCH, PH_BRAKE_CAPTURE: begin
            if (item.still_braking) begin
              done = 1'b1;
            end else begin
              result.stop_request         = REQ_COAST;
              state_next.phase            = (cur_phase == PH_BRAKE_CAPTURE || visible) ?
                                            PH_CONFIRM : PH_SEARCH;
              state_next.phase_start_time = item.now_ms;
              state_next.candidate        = 1'b0;
            end
          end
          PH_SEARCH: begin
            state_next.candidate     = visible;
            state_next.centred_since = since_base;
            if (centred_hit) begin
              result.stop_request  = REQ_BRAKE;
              state_next.phase     = PH_BRAKE_CAPTURE;
              state_next.candidate = 1'b0;
            end
          end
          PH_CONFIRM: begin
            state_next.candidate     = visible;
            state_next.centred_since = since_base;
            if (centred_hit) begin
              state_next.phase = PH_CAPTURED;
              result.outcome   = OUT_CAPTURED;
              done             = 1'b1;
            end else if (phase_elapsed >= {16'd0, cfg.stationary_ms}) begin
              state_next.phase     = PH_SEARCH;
              state_next.candidate = 1'b0;
            end
          end
          default: begin
            // idle and the unused code answer busy
          end
        endcase
        // Rotate in place while searching
        if (!done && state_next.phase == PH_SEARCH) begin
          result.wheels_valid = 1'b1;
          result.left_speed   = state.side_right ? mag : neg;
          result.right_speed  = state.side_right ? neg : mag;
        end
      end
      OP_BEGIN, OP_BEGIN_CORNER: begin
        state_next.side_right       = item.prefer_right;
        state_next.candidate        = 1'b0;
        state_next.reason_store     = REASON_NONE;
        state_next.phase_start_time = item.now_ms;
        if (item.opcode == OP_BEGIN) begin
          result.stop_request = REQ_BRAKE;
          state_next.phase    = PH_BRAKE_SEARCH;
        end else begin
          state_next.phase = PH_SEARCH;
        end
        if (item.drive_fault) begin
          result.stop_request     = REQ_COAST;
          state_next.reason_store = REASON_FAULT;
          state_next.phase        = PH_FAULT;
        end
        result.search_direction = item.prefer_right;
      end
      OP_RESET: begin
        if (state.phase != PH_IDLE) begin
          result.stop_request = REQ_COAST;
        end
        state_next.phase        = PH_IDLE;
        state_next.reason_store = REASON_NONE;
        state_next.candidate    = 1'b0;
      end
      OP_COMMIT: begin
        state_next.phase        = PH_IDLE;
        state_next.reason_store = REASON_NONE;
      end
      OP_STOP: begin
        result.stop_request     = REQ_COAST;
        state_next.reason_store = item.stop_cause;
        state_next.phase        = PH_FAULT;
      end
      default: begin
        // unused opcodes change nothing
      end
    endcase

    result.halt_reason = state_next.reason_store;
  end

endmodule

// File: design/line_recovery_sequencer.sv
// Recovery sequencer for a line-following drive. Each input word is one
// opcode (step, begin, begin at a corner, reset, commit, stop) with sensor
// bits and a millisecond timestamp, and yields exactly one result word. The
// phase and timers update at the edge the word is accepted and the result
// lands in an output register, so one word per cycle is sustained; in_ready
// drops only while a result is held back by out_ready. The three settings
// registers are written through the cfg channel, which is always ready;
// write them only while no result is pending. Writes to index 3 are ignored.
module line_recovery_sequencer (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // input words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic               prefer_right,
  input  logic               sensor_one,
  input  logic               sensor_two,
  input  logic               sensor_three,
  input  logic               sensor_four,
  input  logic [31:0]        now_ms,
  input  logic               drive_fault,
  input  logic               still_braking,
  input  logic [2:0]         stop_cause,
  // result words
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         outcome,
  output logic [1:0]         stop_request,
  output logic               wheels_valid,
  output logic signed [15:0] left_speed,
  output logic signed [15:0] right_speed,
  output logic               search_direction,
  output logic [2:0]         halt_reason
);
  import lrs_pkg::*;

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  item_t   item;
  result_t result;
  result_t result_reg;
  logic    in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  assign item.opcode        = opcode;
  assign item.prefer_right  = prefer_right;
  assign item.sensor_one    = sensor_one;
  assign item.sensor_two    = sensor_two;
  assign item.sensor_three  = sensor_three;
  assign item.sensor_four   = sensor_four;
  assign item.now_ms        = now_ms;
  assign item.drive_fault   = drive_fault;
  assign item.still_braking = still_braking;
  assign item.stop_cause    = stop_cause;

  lrs_step u_step (
    .cfg        (cfg),
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .result     (result)
  );

  // Settings registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.search_speed  <= SPEED_RESET;
      cfg.confirm_ms    <= CONFIRM_RESET;
      cfg.stationary_ms <= STATIONARY_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SEARCH_SPEED:  cfg.search_speed  <= cfg_data[14:0];
        CFG_CONFIRM_MS:    cfg.confirm_ms    <= cfg_data;
        CFG_STATIONARY_MS: cfg.stationary_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Advance sequencer state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Output register: hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_reg <= result;
    end
  end

  assign outcome          = result_reg.outcome;
  assign stop_request     = result_reg.stop_request;
  assign wheels_valid     = result_reg.wheels_valid;
  assign left_speed       = result_reg.left_speed;
  assign right_speed      = result_reg.right_speed;
  assign search_direction = result_reg.search_direction;
  assign halt_reason      = result_reg.halt_reason;

  // Wheel commands only come out of the search phase
  assert property (@(posedge clk) disable iff (rst)
    out_valid && wheels_valid |-> state.phase == PH_SEARCH)
    else $error("wheel speeds issued outside search");

  // A captured answer leaves the block in the captured phase
  assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_CAPTURED |-> state.phase == PH_CAPTURED)
    else $error("captured outcome without captured phase");

  // A failed answer leaves the block in the fault phase
  assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_FAILED |-> state.phase == PH_FAULT)
    else $error("failed outcome without fault phase");

  // A stored reason only exists while latched in fault
  assert property (@(posedge clk) disable iff (rst)
    state.reason_store != REASON_NONE |-> state.phase == PH_FAULT)
    else $error("stop reason held outside fault phase");

endmodule
